// ===== hw/rtl/phs_pkg.sv =====
// Shared types and constants for the per-channel histogram statistics block.
package phs_pkg;

  // Function codes carried by each request item
  localparam logic [1:0] FUNC_CLEAR    = 2'd0;
  localparam logic [1:0] FUNC_ACC      = 2'd1;
  localparam logic [1:0] FUNC_RD_BIN   = 2'd2;
  localparam logic [1:0] FUNC_RD_STATS = 2'd3;

  localparam logic [4:0]  BPP_MIN    = 5'd8;
  localparam logic [4:0]  BPP_MAX    = 5'd16;
  localparam logic [4:0]  BPP_RESET  = 5'd8;
  localparam logic [15:0] MIN_RESET  = 16'h00FF;
  localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;
  localparam int          MEAN_W     = 24;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  channel;
    logic [15:0] pixel_value;
    logic [7:0]  bin_index;
  } phs_req_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [15:0] min_value;
    logic [15:0] max_value;
    logic [47:0] pixel_sum;
    logic [31:0] pixel_count;
    logic [23:0] mean_q8;
  } phs_rsp_t;

  // One channel's running statistics
  typedef struct packed {
    logic [15:0] min_value;
    logic [15:0] max_value;
    logic [47:0] pixel_sum;
    logic [31:0] pixel_count;
  } phs_chan_stats_t;

  // Pixel update toward the channel statistics
  typedef struct packed {
    logic        en;
    logic [1:0]  channel;
    logic [15:0] pixel;
  } phs_upd_t;

endpackage

// ===== hw/rtl/per_channel_histogram_stats.sv =====
// Top level: per-channel histogram with minimum, maximum, sum, count and mean.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req (phs_req_t)
//   rsp      out        rsp_valid / rsp_stall  rsp (phs_rsp_t)
//   cfg      in         cfg_we                 cfg_wdata (bits per pixel)
//
// Accumulate items enter every cycle while req_stall is low; the bin
// read-modify-write uses the registered memory read with forwarding
// from the previous write. Read bin passes the data stage and the output
// register; read stats waits on the 24-step divider. Clear, and reset,
// sweep the bin memory, one entry per cycle, over NUM_CHANNELS rounded up
// to a power of two (at least two), times 2^clog2(NUM_BINS) entries.
// A read bin result waiting on rsp_stall holds the pipeline and req_stall.
module per_channel_histogram_stats #(
  parameter int NUM_BINS     = 256,
  parameter int NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  phs_pkg::phs_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output phs_pkg::phs_rsp_t rsp,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);
  import phs_pkg::*;

  localparam int ChW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IdxW     = $clog2(NUM_BINS);
  localparam int AW       = ChW + IdxW;
  localparam int BinsLog2 = $clog2(NUM_BINS + 1) - 1;

  // Configuration
  logic [4:0]  bpp;
  logic [4:0]  eff_bpp;
  logic [15:0] pix_mask;
  logic [4:0]  bin_shift;

  // Request decode
  logic            accept;
  logic [15:0]     pix_m;
  logic [15:0]     idx_full;
  logic [IdxW-1:0] acc_idx;
  logic            ch_ok;
  logic            bin_ok;
  logic [AW-1:0]   rd_addr;

  // Stage holding the item whose bin data is available
  logic          s_vld;
  logic [1:0]    s_func;
  logic [1:0]    s_channel;
  logic          s_ch_ok;
  logic          s_bin_ok;
  logic [15:0]   s_pix;
  logic [AW-1:0] s_addr;
  logic          s_hold;

  // Memory ports and forwarding
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;
  logic          w_vld;
  logic [AW-1:0] w_addr;
  logic [31:0]   w_data;
  logic [31:0]   bin_val;
  logic [31:0]   bin_inc;
  logic          s_acc_we;

  // Clear sweep
  logic          sweeping;
  logic [AW-1:0] swp_addr;

  // Statistics and mean
  phs_upd_t        upd;
  phs_chan_stats_t rd_stats;
  phs_chan_stats_t st_hold;
  logic            div_start;
  logic            div_busy;
  logic            div_done;
  logic            div_ack;
  logic [23:0]     div_q;

  logic out_free;

  // Hold the bits-per-pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp <= BPP_RESET;
    end else if (cfg_we) begin
      bpp <= cfg_wdata;
    end
  end

  // Clamp the width and derive mask and bin shift
  assign eff_bpp   = (bpp < BPP_MIN) ? BPP_MIN : ((bpp > BPP_MAX) ? BPP_MAX : bpp);
  assign pix_mask  = 16'hFFFF >> (BPP_MAX - eff_bpp);
  assign bin_shift = eff_bpp - 5'(BinsLog2);

  // Decode the incoming item into a bin address
  assign accept   = req_valid & ~req_stall;
  assign pix_m    = req.pixel_value & pix_mask;
  assign idx_full = pix_m >> bin_shift;
  assign acc_idx  = (idx_full >= 16'(NUM_BINS)) ? IdxW'(NUM_BINS - 1) : idx_full[IdxW-1:0];
  assign ch_ok    = (3'(req.channel) < 3'(NUM_CHANNELS));
  assign bin_ok   = (16'(req.bin_index) < 16'(NUM_BINS));
  assign rd_addr  = (req.func == FUNC_RD_BIN) ?
                    {req.channel[ChW-1:0], req.bin_index[IdxW-1:0]} :
                    {req.channel[ChW-1:0], acc_idx};

  // Stall while sweeping, dividing, or finishing a non-accumulate item
  assign req_stall = sweeping | div_busy | (s_vld & (s_func != FUNC_ACC));

  assign out_free = ~rsp_valid | ~rsp_stall;
  assign s_hold   = s_vld & (s_func == FUNC_RD_BIN) & ~out_free;

  // Advance the data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (!s_hold) begin
      s_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_func    <= req.func;
      s_channel <= req.channel;
      s_ch_ok   <= ch_ok;
      s_bin_ok  <= bin_ok;
      s_pix     <= pix_m;
      s_addr    <= rd_addr;
    end
  end

  // Forward the last write when it hit the entry just read
  assign bin_val  = (w_vld && (w_addr == s_addr)) ? w_data : mem_rdata;
  assign bin_inc  = (bin_val == CNT_MAX) ? bin_val : bin_val + 32'd1;
  assign s_acc_we = s_vld & (s_func == FUNC_ACC) & s_ch_ok;

  // Pick the sweep or the bin increment for the write port
  assign mem_we    = sweeping | s_acc_we;
  assign mem_waddr = sweeping ? swp_addr : s_addr;
  assign mem_wdata = sweeping ? 32'd0 : bin_inc;

  // Track the last write; freeze while a read waits
  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
    end else if (!s_hold) begin
      w_vld <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (!s_hold) begin
      w_addr <= mem_waddr;
      w_data <= mem_wdata;
    end
  end

  phs_bin_mem #(
    .ADDR_W (AW)
  ) u_bin_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // Sweep all bins to zero after reset and on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b1;
      swp_addr <= '0;
    end else if (sweeping) begin
      swp_addr <= swp_addr + 1'b1;
      if (swp_addr == {AW{1'b1}}) begin
        sweeping <= 1'b0;
      end
    end else if (s_vld && (s_func == FUNC_CLEAR)) begin
      sweeping <= 1'b1;
      swp_addr <= '0;
    end
  end

  // Channel statistics
  assign upd = '{en: s_acc_we, channel: s_channel, pixel: s_pix};

  phs_chan_stats #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan_stats (
    .clk        (clk),
    .rst        (rst),
    .clear      (s_vld && (s_func == FUNC_CLEAR)),
    .clear_min  (pix_mask),
    .upd        (upd),
    .rd_channel (s_channel),
    .rd_stats   (rd_stats)
  );

  // Capture the queried channel and start the mean
  assign div_start = s_vld & (s_func == FUNC_RD_STATS);

  always_ff @(posedge clk) begin
    if (div_start) begin
      st_hold <= rd_stats;
    end
  end

  phs_mean_div u_mean_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (rd_stats.pixel_sum),
    .count    (rd_stats.pixel_count),
    .ack      (div_ack),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_ack = div_done & out_free;

  // Load the output register with a bin result or a stats result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s_vld && (s_func == FUNC_RD_BIN) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (div_ack) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld && (s_func == FUNC_RD_BIN) && out_free) begin
      rsp.bin_count   <= (s_ch_ok && s_bin_ok) ? bin_val : 32'd0;
      rsp.min_value   <= '0;
      rsp.max_value   <= '0;
      rsp.pixel_sum   <= '0;
      rsp.pixel_count <= '0;
      rsp.mean_q8     <= '0;
    end else if (div_ack) begin
      rsp.bin_count   <= '0;
      rsp.min_value   <= st_hold.min_value;
      rsp.max_value   <= st_hold.max_value;
      rsp.pixel_sum   <= st_hold.pixel_sum;
      rsp.pixel_count <= st_hold.pixel_count;
      rsp.mean_q8     <= (st_hold.pixel_count == '0) ? 24'd0 : div_q;
    end
  end

endmodule

// ===== hw/rtl/phs_bin_mem.sv =====
// Histogram bin memory: one write port, one registered read port.
module phs_bin_mem #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [1 << ADDR_W];

  // Write the bin
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the bin into a registered output; hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/phs_chan_stats.sv =====
// Per-channel minimum, maximum, sum and count registers.
module phs_chan_stats #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic [15:0]             clear_min,
  input  phs_pkg::phs_upd_t       upd,
  input  logic [1:0]              rd_channel,
  output phs_pkg::phs_chan_stats_t rd_stats
);
  import phs_pkg::*;

  localparam int ChW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ChSlots = 1 << ChW;

  phs_chan_stats_t stats [ChSlots];
  phs_chan_stats_t cur;
  logic [ChW-1:0]  usel;
  logic [ChW-1:0]  rsel;
  logic            rd_ok;

  assign usel  = upd.channel[ChW-1:0];
  assign rsel  = rd_channel[ChW-1:0];
  assign rd_ok = (3'(rd_channel) < 3'(NUM_CHANNELS));
  assign cur   = stats[usel];

  // Update the addressed channel, or reset every channel on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < ChSlots; c++) begin
        stats[c] <= '{min_value: MIN_RESET, max_value: '0, pixel_sum: '0, pixel_count: '0};
      end
    end else if (clear) begin
      for (int c = 0; c < ChSlots; c++) begin
        stats[c] <= '{min_value: clear_min, max_value: '0, pixel_sum: '0, pixel_count: '0};
      end
    end else if (upd.en) begin
      if (upd.pixel > cur.max_value) begin
        stats[usel].max_value <= upd.pixel;
      end
      if (upd.pixel < cur.min_value) begin
        stats[usel].min_value <= upd.pixel;
      end
      // Freeze count and sum together once the count saturates
      if (cur.pixel_count != CNT_MAX) begin
        stats[usel].pixel_count <= cur.pixel_count + 32'd1;
        stats[usel].pixel_sum   <= cur.pixel_sum + 48'(upd.pixel);
      end
    end
  end

  // Return zeros for a channel beyond the configured count
  assign rd_stats = rd_ok ? stats[rsel] : '0;

endmodule

// ===== hw/rtl/phs_mean_div.sv =====
// Iterative restoring divider for the Q8 mean, one quotient bit per cycle.
module phs_mean_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] sum,
  input  logic [31:0] count,
  input  logic        ack,
  output logic        busy,
  output logic        done,
  output logic [23:0] quotient
);
  import phs_pkg::*;

  localparam int StepW = $clog2(MEAN_W);

  logic             run;
  logic [StepW-1:0] step;
  logic [31:0]      rem;
  logic [23:0]      lo;
  logic [31:0]      divisor;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             qbit;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem, lo[23]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = ~diff[32];

  // Sequence the steps and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      step <= StepW'(MEAN_W - 1);
    end else if (run) begin
      step <= step - 1'b1;
      if (step == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else if (done && ack) begin
      done <= 1'b0;
    end
  end

  // Datapath: the dividend is sum shifted up by eight fraction bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= sum[47:16];
      lo       <= {sum[15:0], 8'h00};
      divisor  <= count;
      quotient <= '0;
    end else if (run) begin
      rem      <= qbit ? diff[31:0] : trial[31:0];
      lo       <= {lo[22:0], 1'b0};
      quotient <= {quotient[22:0], qbit};
    end
  end

  assign busy = run | done;

endmodule

// ===== tb/per_channel_histogram_stats_test.sv =====
// Self-checking testbench for the per-channel histogram statistics block.
module per_channel_histogram_stats_test;
  timeunit 1ns;
  timeprecision 1ps;

  import phs_pkg::*;

  localparam int NB          = 256;
  localparam int NC          = 4;
  localparam int BIN_BITS    = $clog2(NB);
  localparam int SWEEP_WAIT  = (1 << $clog2(NC)) * (1 << $clog2(NB)) + 64;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 108;

  typedef struct {
    phs_req_t item;
    bit       fixed;
    phs_rsp_t answer;
  } table_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid;
  logic     req_stall;
  phs_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  phs_rsp_t rsp;
  logic     cfg_we;
  logic [4:0] cfg_wdata;

  // Shadow of the block's state and register
  logic [4:0]  cfg_bpp;
  logic [31:0] bin_tally [NC][NB];
  logic [15:0] ch_min [NC];
  logic [15:0] ch_max [NC];
  logic [47:0] ch_sum [NC];
  logic [31:0] ch_cnt [NC];
  logic [7:0]  last_bin [NC];

  phs_rsp_t answers_due [$];
  phs_rsp_t want_rsp;
  int       errors = 0;
  int       quiet_cycles;
  bit       idle_on = 1'b0;
  bit       hold_off = 1'b0;

  logic [4:0] widths [PHASES] = '{5'd8, 5'd16, 5'd12, 5'd0, 5'd31, 5'd10, 5'd7, 5'd17,
                                  5'd9, 5'd15, 5'd8};

  per_channel_histogram_stats #(
    .NUM_BINS     (NB),
    .NUM_CHANNELS (NC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Effective sample width: clamp the register into 8..16
  function automatic int unsigned width_in_use();
    if (cfg_bpp < BPP_MIN) return BPP_MIN;
    if (cfg_bpp > BPP_MAX) return BPP_MAX;
    return cfg_bpp;
  endfunction

  task automatic wipe_stats();
    int unsigned top;
    top = (1 << width_in_use()) - 1;
    for (int c = 0; c < NC; c++) begin
      ch_min[c] = top[15:0];
      ch_max[c] = '0;
      ch_sum[c] = '0;
      ch_cnt[c] = '0;
      last_bin[c] = '0;
      for (int b = 0; b < NB; b++) bin_tally[c][b] = '0;
    end
  endtask

  // Advance the shadow state by one item and work out its result, if any
  task automatic predict_histogram(input phs_req_t q, output bit gives, output phs_rsp_t a);
    int unsigned w, px, idx;
    logic [63:0] num, quot;
    a = '0;
    gives = 1'b0;
    case (q.func)
      FUNC_CLEAR: wipe_stats();
      FUNC_ACC: begin
        if (q.channel < NC) begin
          w = width_in_use();
          px = q.pixel_value & ((1 << w) - 1);
          idx = px >> (w - BIN_BITS);
          if (idx >= NB) idx = NB - 1;
          if (bin_tally[q.channel][idx] != CNT_MAX)
            bin_tally[q.channel][idx] = bin_tally[q.channel][idx] + 1;
          if (px > ch_max[q.channel]) ch_max[q.channel] = px[15:0];
          if (px < ch_min[q.channel]) ch_min[q.channel] = px[15:0];
          if (ch_cnt[q.channel] != CNT_MAX) begin
            ch_cnt[q.channel] = ch_cnt[q.channel] + 1;
            ch_sum[q.channel] = ch_sum[q.channel] + px;
          end
          last_bin[q.channel] = idx[7:0];
        end
      end
      FUNC_RD_BIN: begin
        gives = 1'b1;
        if (q.channel < NC && q.bin_index < NB)
          a.bin_count = bin_tally[q.channel][q.bin_index];
      end
      default: begin
        gives = 1'b1;
        if (q.channel < NC) begin
          a.min_value = ch_min[q.channel];
          a.max_value = ch_max[q.channel];
          a.pixel_sum = ch_sum[q.channel];
          a.pixel_count = ch_cnt[q.channel];
          if (ch_cnt[q.channel] != 0) begin
            num = {8'h00, ch_sum[q.channel], 8'h00};
            quot = num / {32'h0, ch_cnt[q.channel]};
            a.mean_q8 = (quot > 64'hFF_FFFF) ? 24'hFF_FFFF : quot[23:0];
          end
        end
      end
    endcase
  endtask

  // Random item: mostly pixels, half the bin reads aimed at the last bin hit
  function automatic phs_req_t pick_request();
    phs_req_t q;
    int unsigned roll, w, top, pix;
    roll = $urandom_range(0, 999);
    w = width_in_use();
    top = (1 << w) - 1;
    q.func = (roll < 4) ? FUNC_CLEAR : (roll < 700) ? FUNC_ACC :
             (roll < 850) ? FUNC_RD_BIN : FUNC_RD_STATS;
    q.channel = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: pix = $urandom;
      1: pix = $urandom & top;
      2: begin
        case ($urandom_range(0, 2))
          0: pix = 0;
          1: pix = top;
          default: pix = 16'hFFFF;
        endcase
      end
      default: pix = top - $urandom_range(0, 15);
    endcase
    q.pixel_value = pix[15:0];
    q.bin_index = $urandom_range(0, 1) ? last_bin[q.channel] : 8'($urandom);
    return q;
  endfunction

  function automatic table_row_t mk(input logic [1:0] f, input logic [1:0] c,
                                    input logic [15:0] p, input logic [7:0] b,
                                    input bit fixed, input phs_rsp_t w);
    table_row_t r;
    r.item.func = f;
    r.item.channel = c;
    r.item.pixel_value = p;
    r.item.bin_index = b;
    r.fixed = fixed;
    r.answer = w;
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) note_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Offer one item, hold it until taken, then queue its result
  task automatic offer(input phs_req_t q, input bit fixed, input phs_rsp_t fixed_answer);
    int gap;
    bit gives;
    phs_rsp_t a;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predict_histogram(q, gives, a);
    if (gives) answers_due.push_back(fixed ? fixed_answer : a);
  endtask

  // Drop valid, drain results, then let a clear sweep finish
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SWEEP_WAIT) @(posedge clk);
  endtask

  task automatic write_width(input logic [4:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_bpp = v;
  endtask

  // Receiver: short random stalls, or one long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compare each result with the oldest outstanding answer
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (answers_due.size() == 0) begin
        note_error("result with nothing outstanding");
      end else begin
        want_rsp = answers_due.pop_front();
        check_field("bin_count", rsp.bin_count, want_rsp.bin_count);
        check_field("min_value", rsp.min_value, want_rsp.min_value);
        check_field("max_value", rsp.max_value, want_rsp.max_value);
        check_field("pixel_sum", rsp.pixel_sum, want_rsp.pixel_sum);
        check_field("pixel_count", rsp.pixel_count, want_rsp.pixel_count);
        check_field("mean_q8", rsp.mean_q8, want_rsp.mean_q8);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_valid && req_stall === 1'b0) ||
                 (rsp_valid === 1'b1 && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    phs_req_t q;
    phs_rsp_t fresh, nothing;
    table_row_t plan [$];
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fresh = '0;
    fresh.min_value = MIN_RESET;
    nothing = '0;

    // Directed table: reset values, field extremes, every function
    plan.push_back(mk(FUNC_RD_STATS, 2'd0, 16'h0000, 8'h00, 1, fresh));
    plan.push_back(mk(FUNC_RD_STATS, 2'd3, 16'hFFFF, 8'hFF, 1, fresh));
    plan.push_back(mk(FUNC_RD_BIN, 2'd3, 16'hFFFF, 8'hFF, 1, nothing));
    plan.push_back(mk(FUNC_RD_BIN, 2'd0, 16'h0000, 8'h00, 1, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd0, 16'h0000, 8'h00, 0, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd0, 16'h00FF, 8'h00, 0, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd0, 16'hFFFF, 8'hFF, 0, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd1, 16'h1234, 8'h55, 0, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd2, 16'h0080, 8'hAA, 0, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd3, 16'hFF00, 8'h00, 0, nothing));
    plan.push_back(mk(FUNC_ACC, 2'd1, 16'h0001, 8'hFF, 0, nothing));
    plan.push_back(mk(FUNC_RD_BIN, 2'd0, 16'h0000, 8'h00, 0, nothing));
    plan.push_back(mk(FUNC_RD_BIN, 2'd0, 16'hFFFF, 8'hFF, 0, nothing));
    plan.push_back(mk(FUNC_RD_BIN, 2'd1, 16'h0000, 8'h34, 0, nothing));
    plan.push_back(mk(FUNC_RD_BIN, 2'd3, 16'h0000, 8'h00, 0, nothing));
    for (int c = 0; c < NC; c++)
      plan.push_back(mk(FUNC_RD_STATS, c[1:0], 16'h0000, 8'h00, 0, nothing));
    plan.push_back(mk(FUNC_CLEAR, 2'd2, 16'hFFFF, 8'hFF, 0, nothing));
    plan.push_back(mk(FUNC_RD_STATS, 2'd0, 16'h0000, 8'h00, 1, fresh));
    plan.push_back(mk(FUNC_RD_BIN, 2'd0, 16'h0000, 8'hFF, 1, nothing));
    plan.push_back(mk(FUNC_RD_STATS, 2'd2, 16'h0000, 8'h00, 1, fresh));

    // Hold reset, then mirror it in the shadow state
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    cfg_bpp = BPP_RESET;
    wipe_stats();

    idle_on = 1'b1;
    foreach (plan[i]) offer(plan[i].item, plan[i].fixed, plan[i].answer);

    // One phase per sample width; the last phase runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        write_width(widths[ph]);
      end
      if (ph % 2 == 1) begin
        q = pick_request();
        q.func = FUNC_CLEAR;
        offer(q, 0, nothing);
      end
      if (ph == 2) begin
        // Long receiver hold-off while reads keep coming
        hold_off = 1'b1;
        for (int n = 0; n < 40; n++) begin
          q = pick_request();
          q.func = ($urandom_range(0, 2) != 0) ? FUNC_RD_BIN : FUNC_ACC;
          offer(q, 0, nothing);
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
        offer(pick_request(), 0, nothing);
      end
    end

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
